@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_CHECK(lbl, clk, rst, !(cond), msg)

`endif

@@ rtl/pcae_pkg.sv @@
// Package for the point cloud axis extremes block: constants and types.
package pcae_pkg;

  localparam int DEFAULT_COORD_BITS = 32;
  localparam int NUM_KINDS          = 6;
  localparam int NUM_AXES           = 3;
  localparam int KIND_BITS          = 3;
  localparam int VERTEX_BITS        = 32;
  localparam int QUEUE_DEPTH        = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_MIN_X = 3'd0,
    KIND_MAX_X = 3'd1,
    KIND_MIN_Y = 3'd2,
    KIND_MAX_Y = 3'd3,
    KIND_MIN_Z = 3'd4,
    KIND_MAX_Z = 3'd5
  } kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pcae_q_status_t;

endpackage

@@ rtl/pcae_if.sv @@
// Stream interfaces: input points and output extreme vertices.
interface pcae_point_if #(
  parameter int COORD_BITS = pcae_pkg::DEFAULT_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         cloud_end;

  modport source (output valid, coord_x, coord_y, coord_z, cloud_end, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, cloud_end, output ready);
endinterface

interface pcae_vertex_if;
  import pcae_pkg::*;
  logic                          valid;
  logic                          ready;
  logic        [KIND_BITS-1:0]   extreme_kind;
  logic signed [VERTEX_BITS-1:0] vertex_x;
  logic signed [VERTEX_BITS-1:0] vertex_y;
  logic signed [VERTEX_BITS-1:0] vertex_z;
  logic                          final_vertex;

  modport source (output valid, extreme_kind, vertex_x, vertex_y, vertex_z, final_vertex,
                  input ready);
  modport sink   (input valid, extreme_kind, vertex_x, vertex_y, vertex_z, final_vertex,
                  output ready);
endinterface

@@ rtl/point_cloud_axis_extremes.sv @@
// Top level of the point cloud axis extremes block.
// Takes one point per cycle and keeps, per axis, the earliest point holding the
// smallest and the largest signed coordinate. The point that closes a cloud
// pushes a snapshot of all six into a two-entry queue; the back end then sends
// six results, min x to max z, one per cycle while the sink is ready, the last
// flagged final_vertex. Input throughput is one point per cycle; it stalls only
// while the queue holds two undelivered clouds. The closing point's snapshot is
// written into the queue, and the back end then registers the first result into
// its output stage.
module point_cloud_axis_extremes #(
  parameter int COORD_BITS = pcae_pkg::DEFAULT_COORD_BITS
) (
  input logic           clk,
  input logic           rst,
  pcae_point_if.sink    points,
  pcae_vertex_if.source vertices
);
  import pcae_pkg::*;
  `include "assert_macros.svh"

  logic [NUM_KINDS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] push_data;
  logic [NUM_KINDS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] head_data;
  logic                                                q_push;
  logic                                                q_pop;
  pcae_q_status_t                                      q_stat;

  pcae_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (push_data)
  );

  pcae_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head_data),
    .stat    (q_stat)
  );

  pcae_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .q_data   (head_data),
    .q_pop    (q_pop),
    .vertices (vertices)
  );

  `ASSERT_NEVER(a_queue_no_overflow, clk, rst, q_push && q_stat.full, "queue overflow")
  `ASSERT_NEVER(a_queue_no_underflow, clk, rst, q_pop && q_stat.empty, "queue underflow")
  `ASSERT_CHECK(a_end_fills_queue, clk, rst, q_push |=> !q_stat.empty, "snapshot lost")
  `ASSERT_CHECK(a_pop_on_final, clk, rst,
                q_pop |=> (vertices.valid && vertices.final_vertex &&
                           vertices.extreme_kind == KIND_MAX_Z), "pop without final vertex")

endmodule

@@ rtl/pcae_front.sv @@
// Front end: takes points and tracks the six axis extremes of the open cloud.
module pcae_front #(
  parameter int COORD_BITS = pcae_pkg::DEFAULT_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  pcae_point_if.sink             points,
  input  pcae_pkg::pcae_q_status_t q_stat,
  output logic                   q_push,
  output logic [pcae_pkg::NUM_KINDS-1:0][pcae_pkg::NUM_AXES-1:0][COORD_BITS-1:0] q_data
);
  import pcae_pkg::*;

  logic [NUM_AXES-1:0][COORD_BITS-1:0]                 pt;
  logic [NUM_KINDS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] ext;
  logic [NUM_KINDS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] ext_next;
  logic                                                started;
  logic                                                accept;

  assign points.ready = !q_stat.full;
  assign accept       = points.valid && points.ready;

  assign pt[0] = points.coord_x;
  assign pt[1] = points.coord_y;
  assign pt[2] = points.coord_z;

  always_comb begin
    ext_next = ext;
    if (!started) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        ext_next[k] = pt;
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if ($signed(pt[a]) < $signed(ext[2*a][a])) begin
          ext_next[2*a] = pt;
        end
        if ($signed(pt[a]) > $signed(ext[2*a+1][a])) begin
          ext_next[2*a+1] = pt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ext <= ext_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (accept) begin
      started <= !points.cloud_end;
    end
  end

  // snapshot includes the final point's update
  assign q_push = accept && points.cloud_end;
  assign q_data = ext_next;

endmodule

@@ rtl/pcae_queue.sv @@
// Short queue of finished cloud snapshots between front and back.
module pcae_queue #(
  parameter int COORD_BITS = pcae_pkg::DEFAULT_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [pcae_pkg::NUM_KINDS-1:0][pcae_pkg::NUM_AXES-1:0][COORD_BITS-1:0] wr_data,
  input  logic                     pop,
  output logic [pcae_pkg::NUM_KINDS-1:0][pcae_pkg::NUM_AXES-1:0][COORD_BITS-1:0] rd_data,
  output pcae_pkg::pcae_q_status_t stat
);
  import pcae_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [NUM_KINDS-1:0][NUM_AXES-1:0][COORD_BITS-1:0] entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]                                wr_ptr;
  logic [PTR_BITS-1:0]                                rd_ptr;
  logic [CNT_BITS-1:0]                                count;

  assign stat.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/pcae_back.sv @@
// Back end: plays out the six extreme vertices of each queued cloud.
module pcae_back #(
  parameter int COORD_BITS = pcae_pkg::DEFAULT_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pcae_pkg::pcae_q_status_t q_stat,
  input  logic [pcae_pkg::NUM_KINDS-1:0][pcae_pkg::NUM_AXES-1:0][COORD_BITS-1:0] q_data,
  output logic                     q_pop,
  pcae_vertex_if.source            vertices
);
  import pcae_pkg::*;

  kind_t                               kind;
  logic                                load;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] sel;
  logic [VERTEX_BITS-1:0]              vtx [NUM_AXES];

  assign load  = !q_stat.empty && (!vertices.valid || vertices.ready);
  assign q_pop = load && (kind == KIND_MAX_Z);
  assign sel   = q_data[kind];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_widen
    if (COORD_BITS >= VERTEX_BITS) begin : g_trunc
      assign vtx[a] = sel[a][VERTEX_BITS-1:0];
    end else begin : g_zext
      assign vtx[a] = {{(VERTEX_BITS-COORD_BITS){1'b0}}, sel[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertices.valid <= 1'b0;
      kind           <= KIND_MIN_X;
    end else begin
      if (load) begin
        vertices.valid <= 1'b1;
        kind <= (kind == KIND_MAX_Z) ? KIND_MIN_X : kind_t'(kind + 3'd1);
      end else if (vertices.ready) begin
        vertices.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertices.extreme_kind <= kind;
      vertices.vertex_x     <= vtx[0];
      vertices.vertex_y     <= vtx[1];
      vertices.vertex_z     <= vtx[2];
      vertices.final_vertex <= (kind == KIND_MAX_Z);
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for point_cloud_axis_extremes: table-driven and random clouds.
`timescale 1ns / 1ps

module tb;
  import pcae_pkg::*;

  localparam int COORD_BITS = DEFAULT_COORD_BITS;
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam int RANDOM_POINTS = 78;
  localparam int SINK_HOLD     = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 12;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    kind_t                         kind;
    logic signed [VERTEX_BITS-1:0] x;
    logic signed [VERTEX_BITS-1:0] y;
    logic signed [VERTEX_BITS-1:0] z;
    logic                          last_one;
  } vertex_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    bit                           last;
    bit                           lone;
  } stim_row_t;

  // lone rows open and close a cloud: all six results carry the row's own point
  stim_row_t directed_rows [20] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1},
    '{C_MIN, C_MAX, C_MIN, 1'b1, 1'b1},
    '{C_MAX, C_MIN, C_MAX, 1'b1, 1'b1},
    '{-32'sd1, 32'sd1, 32'sh8000_0001, 1'b1, 1'b1},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF, 1'b1, 1'b1},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_0000, 1'b1, 1'b1},
    '{32'sd5, 32'sd1, -32'sd1, 1'b0, 1'b0},
    '{32'sd5, 32'sd2, -32'sd1, 1'b0, 1'b0},
    '{32'sd5, 32'sd3, -32'sd1, 1'b1, 1'b0},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{C_MIN, C_MIN, C_MIN, 1'b0, 1'b0},
    '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b0},
    '{C_MIN, C_MAX, 32'sd0, 1'b1, 1'b0},
    '{C_MAX, C_MIN, 32'sd1, 1'b0, 1'b0},
    '{C_MIN, C_MAX, -32'sd1, 1'b0, 1'b0},
    '{-32'sd1, 32'sd0, 32'sd1, 1'b1, 1'b0},
    '{32'sd100, -32'sd100, 32'sd50, 1'b0, 1'b0},
    '{-32'sd100, 32'sd100, 32'sd50, 1'b0, 1'b0},
    '{32'sd0, 32'sd0, -32'sd50, 1'b0, 1'b0},
    '{32'sd0, 32'sd0, 32'sd150, 1'b1, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic steady    = 1'b0;
  logic stall_req = 1'b0;

  pcae_point_if #(.COORD_BITS(COORD_BITS)) point_bus ();
  pcae_vertex_if vertex_bus ();

  point_cloud_axis_extremes #(.COORD_BITS(COORD_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .points   (point_bus),
    .vertices (vertex_bus)
  );

  always #10 clk = ~clk;

  point_t  extreme_pts [NUM_KINDS];
  bit      cloud_open = 1'b0;
  vertex_t pending_vertices [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  function automatic logic signed [COORD_BITS-1:0] axis_of(point_t p, int a);
    case (a)
      0: return p.x;
      1: return p.y;
      default: return p.z;
    endcase
  endfunction

  function automatic void expect_vertex(vertex_t v);
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  // Track extremes of the open cloud; on the closing point queue its six vertices if keep is set.
  function automatic void absorb_point(point_t p, bit last, bit keep);
    if (!cloud_open) begin
      foreach (extreme_pts[k]) extreme_pts[k] = p;
      cloud_open = 1'b1;
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if ($signed(axis_of(p, a)) < $signed(axis_of(extreme_pts[2*a], a)))
          extreme_pts[2*a] = p;
        if ($signed(axis_of(p, a)) > $signed(axis_of(extreme_pts[2*a+1], a)))
          extreme_pts[2*a+1] = p;
      end
    end
    if (last) begin
      if (keep) begin
        for (int k = 0; k < NUM_KINDS; k++)
          expect_vertex('{kind_t'(k), extreme_pts[k].x, extreme_pts[k].y,
                          extreme_pts[k].z, k == NUM_KINDS - 1});
      end
      cloud_open = 1'b0;
    end
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return int'($urandom_range(0, 16)) - 8;
      7: return C_MIN;
      8: return C_MAX;
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  task automatic send_point(point_t p, bit last);
    while (!steady && $urandom_range(0, 99) < 13) begin
      point_bus.valid <= 1'b0;
      @(posedge clk);
    end
    point_bus.valid     <= 1'b1;
    point_bus.coord_x   <= p.x;
    point_bus.coord_y   <= p.y;
    point_bus.coord_z   <= p.z;
    point_bus.cloud_end <= last;
    @(posedge clk);
    while (!point_bus.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    point_bus.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  // result side: random backpressure plus one long hold once stall_req rises
  initial begin : sink_side
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    vertex_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        vertex_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_req && !hold_done) begin
        vertex_bus.ready <= 1'b0;
        hold_left = SINK_HOLD - 1;
        hold_done = 1'b1;
      end else begin
        vertex_bus.ready <= steady || $urandom_range(0, 99) >= 13;
      end
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    vertex_t got;
    if (!rst && vertex_bus.valid && vertex_bus.ready) begin
      got = '{kind_t'(vertex_bus.extreme_kind), vertex_bus.vertex_x, vertex_bus.vertex_y,
              vertex_bus.vertex_z, vertex_bus.final_vertex};
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex: kind %0d x %h y %h z %h final %b",
                   got.kind, got.x, got.y, got.z, got.last_one);
      end else begin
        want = pending_vertices.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.last_one !== want.last_one) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("vertex mismatch: expected kind %0d x %h y %h z %h final %b",
                     want.kind, want.x, want.y, want.z, want.last_one);
            $display("                 got      kind %0d x %h y %h z %h final %b",
                     got.kind, got.x, got.y, got.z, got.last_one);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (point_bus.valid && point_bus.ready) || (vertex_bus.valid && vertex_bus.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : point_side
    point_t p;
    int     sent;
    int     len;
    int     clouds;
    rst                 <= 1'b1;
    point_bus.valid     <= 1'b0;
    point_bus.coord_x   <= '0;
    point_bus.coord_y   <= '0;
    point_bus.coord_z   <= '0;
    point_bus.cloud_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      p = '{directed_rows[i].x, directed_rows[i].y, directed_rows[i].z};
      send_point(p, directed_rows[i].last);
      if (directed_rows[i].lone) begin
        for (int k = 0; k < NUM_KINDS; k++)
          expect_vertex('{kind_t'(k), p.x, p.y, p.z, k == NUM_KINDS - 1});
      end
      absorb_point(p, directed_rows[i].last, !directed_rows[i].lone);
    end
    drain_results();

    // short clouds against a held-off sink: queue fills and input stalls
    stall_req <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      p = '{pick_coord(), pick_coord(), pick_coord()};
      send_point(p, ($urandom_range(0, 3) != 0) || (i == 11));
      absorb_point(p, point_bus.cloud_end, 1'b1);
    end

    sent   = 0;
    clouds = 0;
    while (sent < RANDOM_POINTS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      steady <= (sent >= 40 && sent < 75);
      for (int j = 0; j < len; j++) begin
        p = '{pick_coord(), pick_coord(), pick_coord()};
        send_point(p, j == len - 1);
        absorb_point(p, j == len - 1, 1'b1);
        sent++;
      end
      clouds++;
      if (clouds == 8) drain_results();
    end
    steady <= 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_vertices.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
